### hw/rtl/stepper_command_frame_controller_top_macros.svh
// Assertion helpers shared by the controller RTL.
// Both expect signals named clk and rst_n in the scope where they are used.
`ifndef STEPPER_COMMAND_FRAME_CONTROLLER_TOP_MACROS_SVH
`define STEPPER_COMMAND_FRAME_CONTROLLER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SCFC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SCFC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/scfc_pkg.sv
package scfc_pkg;

  // Configuration port geometry and register indexes.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_BOARD_ADDRESS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_HALF_FULL = 2'd1;

  // Input transaction kinds.
  localparam logic FUNC_RX_BYTE    = 1'b0;
  localparam logic FUNC_PULSE_DONE = 1'b1;

  // Characters of the frame protocol.
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_A    = 8'h41;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_ONE  = 8'h31;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_S    = 8'h53;
  localparam logic [7:0] CH_T    = 8'h54;
  localparam logic [7:0] CH_P    = 8'h50;
  localparam logic [7:0] CH_R    = 8'h52;
  localparam logic [7:0] CH_E    = 8'h45;
  localparam logic [7:0] CH_C    = 8'h43;
  localparam logic [7:0] CH_L    = 8'h4C;
  localparam logic [7:0] CH_O    = 8'h4F;
  localparam logic [7:0] CH_Z    = 8'h5A;

  // Frame layout.
  localparam int HDR_BYTES  = 7;
  localparam int STEP_FIRST = 8;
  localparam int STEP_LAST  = 15;
  localparam int SPD_FIRST  = 17;
  localparam int SPD_LAST   = 20;

  // Accumulator widths: eight and four decimal digits.
  localparam int STEP_W = 27;
  localparam int SPD_W  = 14;
  localparam int REM_W  = 28;

  typedef logic [7:0] byte_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

endpackage

### hw/rtl/scfc_in_if.sv
interface scfc_in_if import scfc_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  func;
  byte_t rx_byte;

  modport source (output valid, output func, output rx_byte, input ready);
  modport sink (input valid, input func, input rx_byte, output ready);
endinterface

### hw/rtl/scfc_out_if.sv
interface scfc_out_if import scfc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               motor_enable;
  logic               pulses_running;
  logic               direction_ccw;
  logic               half_full;
  logic               control_level;
  logic        [15:0] prescale;
  logic signed [31:0] position;
  logic               report_valid;

  modport source (
    output valid, output motor_enable, output pulses_running, output direction_ccw,
    output half_full, output control_level, output prescale, output position,
    output report_valid, input ready
  );
  modport sink (
    input valid, input motor_enable, input pulses_running, input direction_ccw,
    input half_full, input control_level, input prescale, input position,
    input report_valid, output ready
  );
endinterface

### hw/rtl/scfc_cfg_if.sv
interface scfc_cfg_if import scfc_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### hw/rtl/stepper_command_frame_controller_top.sv
// Each result transaction is offered in the cycle after its input transaction is accepted.
// Throughput: one input transaction per cycle; the result register frees in the
// same cycle that its transaction is taken, so input ready only drops on a stall.
// Reset (rst_n low, synchronous): empty frame, motor stopped, enable and control
// pins high, direction and half/full low, position and prescale zero, id 8.
`include "stepper_command_frame_controller_top_macros.svh"

module stepper_command_frame_controller_top import scfc_pkg::*; #(
  parameter int MAX_FRAME = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  scfc_in_if.sink     in_ch,
  scfc_out_if.source  out_ch,
  scfc_cfg_if.sink    cfg_ch
);

  localparam int IDX_W = $clog2(MAX_FRAME + 1);

  // State registers.
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  byte_t                    hdr_r [HDR_BYTES];
  byte_t                    hdr_nxt [HDR_BYTES];
  logic [STEP_W-1:0]        step_val_r, step_val_nxt;
  logic                     step_open_r, step_open_nxt;
  logic [SPD_W-1:0]         spd_val_r, spd_val_nxt;
  logic                     spd_open_r, spd_open_nxt;
  logic signed [REM_W-1:0]  rem_r, rem_nxt;
  logic                     run_r, run_nxt;
  logic [31:0]              pos_r, pos_nxt;
  logic                     en_r, en_nxt;
  logic                     ctrl_r, ctrl_nxt;
  logic                     dir_r, dir_nxt;
  logic                     half_r, half_nxt;
  logic [15:0]              presc_r, presc_nxt;
  logic [3:0]               board_r;
  logic                     report_r, report_nxt;
  logic                     out_valid_r;

  logic in_fire;
  logic cfg_fire;
  logic is_byte;
  logic is_pulse;
  logic is_star;
  logic fresh;
  logic take;
  logic is_digit;
  logic [3:0] digit_val;

  byte_t             hdr_cur [HDR_BYTES];
  logic [STEP_W-1:0] step_val_cur;
  logic              step_open_cur;
  logic [SPD_W-1:0]  spd_val_cur;
  logic              spd_open_cur;

  logic addr_match;
  byte_t res_diff;
  byte_t ctrl_diff;
  logic signed [REM_W-1:0] rem_dec;
  logic signed [REM_W-1:0] rem_inc;
  logic [STEP_W-1:0] step_sum;
  logic [SPD_W-1:0]  spd_sum;
  byte_t digit_diff;

  // Handshakes.
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid;

  assign is_byte  = in_fire && (in_ch.func == FUNC_RX_BYTE);
  assign is_pulse = in_fire && (in_ch.func == FUNC_PULSE_DONE);
  assign is_star  = (in_ch.rx_byte == CH_STAR);
  assign fresh    = (idx_r == '0);
  assign take     = is_byte && !is_star && (idx_r < IDX_W'(MAX_FRAME));

  assign is_digit   = (in_ch.rx_byte >= CH_ZERO) && (in_ch.rx_byte <= CH_NINE);
  assign digit_diff = in_ch.rx_byte - CH_ZERO;
  assign digit_val  = digit_diff[3:0];

  // The first character of a frame sees a cleared header and fresh accumulators.
  always_comb begin
    for (int k = 0; k < HDR_BYTES; k++) begin
      hdr_cur[k] = fresh ? '0 : hdr_r[k];
    end
    step_val_cur  = fresh ? '0 : step_val_r;
    step_open_cur = fresh ? 1'b1 : step_open_r;
    spd_val_cur   = fresh ? '0 : spd_val_r;
    spd_open_cur  = fresh ? 1'b1 : spd_open_r;
  end

  // Decimal accumulation: value * 10 + digit as two shifted adds.
  assign step_sum = (step_val_cur << 3) + (step_val_cur << 1) + STEP_W'(digit_val);
  assign spd_sum  = (spd_val_cur << 3) + (spd_val_cur << 1) + SPD_W'(digit_val);

  // Frame decode terms.
  assign addr_match = (hdr_cur[0] == CH_A)
                   && (hdr_cur[1] == {7'b0011000, board_r[3]})
                   && (hdr_cur[2] == {7'b0011000, board_r[2]})
                   && (hdr_cur[3] == {7'b0011000, board_r[1]})
                   && (hdr_cur[4] == {7'b0011000, board_r[0]});
  assign res_diff  = hdr_cur[4] - CH_ZERO;
  assign ctrl_diff = hdr_cur[5] - CH_ZERO;

  assign rem_dec = rem_r - REM_W'(1);
  assign rem_inc = rem_r + REM_W'(1);

  // Next-state logic for one transaction.
  always_comb begin
    idx_nxt       = idx_r;
    for (int k = 0; k < HDR_BYTES; k++) begin
      hdr_nxt[k] = hdr_r[k];
    end
    step_val_nxt  = step_val_r;
    step_open_nxt = step_open_r;
    spd_val_nxt   = spd_val_r;
    spd_open_nxt  = spd_open_r;
    rem_nxt       = rem_r;
    run_nxt       = run_r;
    pos_nxt       = pos_r;
    en_nxt        = en_r;
    ctrl_nxt      = ctrl_r;
    dir_nxt       = dir_r;
    half_nxt      = half_r;
    presc_nxt     = presc_r;
    report_nxt    = 1'b0;

    if (is_byte) begin
      for (int k = 0; k < HDR_BYTES; k++) begin
        hdr_nxt[k] = hdr_cur[k];
        if (take && (idx_r == IDX_W'(k))) begin
          hdr_nxt[k] = in_ch.rx_byte;
        end
      end
      step_val_nxt  = step_val_cur;
      step_open_nxt = step_open_cur;
      spd_val_nxt   = spd_val_cur;
      spd_open_nxt  = spd_open_cur;

      // Step count digits.
      if (take && step_open_cur && (idx_r >= IDX_W'(STEP_FIRST))
          && (idx_r <= IDX_W'(STEP_LAST))) begin
        if (is_digit) begin
          step_val_nxt = step_sum;
        end else begin
          step_open_nxt = 1'b0;
        end
      end

      // Speed digits.
      if (take && spd_open_cur && (idx_r >= IDX_W'(SPD_FIRST))
          && (idx_r <= IDX_W'(SPD_LAST))) begin
        if (is_digit) begin
          spd_val_nxt = spd_sum;
        end else begin
          spd_open_nxt = 1'b0;
        end
      end

      if (take) begin
        idx_nxt = idx_r + IDX_W'(1);
      end

      // Frame end: decode the command.
      if (is_star) begin
        idx_nxt = '0;
        priority if (addr_match) begin
          en_nxt    = 1'b1;
          dir_nxt   = (hdr_cur[6] == CH_ONE);
          rem_nxt   = (hdr_cur[6] == CH_ONE) ? $signed({1'b0, step_val_cur})
                                             : -$signed({1'b0, step_val_cur});
          presc_nxt = {{(16 - SPD_W){1'b0}}, spd_val_cur} - 16'd1;
          run_nxt   = 1'b1;
        end else if (hdr_cur[1] == CH_S && hdr_cur[2] == CH_T && hdr_cur[3] == CH_P) begin
          en_nxt  = 1'b0;
          run_nxt = 1'b0;
        end else if (hdr_cur[1] == CH_R && hdr_cur[2] == CH_E && hdr_cur[3] == CH_S) begin
          half_nxt = res_diff[0];
        end else if (hdr_cur[1] == CH_C && hdr_cur[2] == CH_T && hdr_cur[3] == CH_R
                     && hdr_cur[4] == CH_L) begin
          ctrl_nxt = ctrl_diff[0];
        end else if (hdr_cur[1] == CH_P && hdr_cur[2] == CH_O && hdr_cur[3] == CH_S) begin
          report_nxt = 1'b1;
        end else if (hdr_cur[1] == CH_Z && hdr_cur[2] == CH_R && hdr_cur[3] == CH_O) begin
          pos_nxt = '0;
        end else begin
        end
      end
    end else if (is_pulse && run_r) begin
      // One step done: counter-clockwise counts down, clockwise up.
      if (dir_r) begin
        rem_nxt = rem_dec;
        pos_nxt = pos_r - 32'd1;
        run_nxt = (rem_dec > 0);
      end else begin
        rem_nxt = rem_inc;
        pos_nxt = pos_r + 32'd1;
        run_nxt = (rem_inc < 0);
      end
    end

    // Configuration writes must arrive only while idle; the block itself does not enforce it.
    if (cfg_fire && (cfg_ch.index == CFG_INITIAL_HALF_FULL)) begin
      half_nxt = cfg_ch.data[0];
    end
  end

  // Frame buffer and accumulators; the first byte of a frame overrides them.
  always_ff @(posedge clk) begin
    for (int k = 0; k < HDR_BYTES; k++) begin
      hdr_r[k] <= hdr_nxt[k];
    end
    step_val_r  <= step_val_nxt;
    step_open_r <= step_open_nxt;
    spd_val_r   <= spd_val_nxt;
    spd_open_r  <= spd_open_nxt;
    rem_r       <= rem_nxt;
  end

  // Control state and pin levels.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      run_r    <= 1'b0;
      pos_r    <= '0;
      en_r     <= 1'b1;
      ctrl_r   <= 1'b1;
      dir_r    <= 1'b0;
      half_r   <= 1'b0;
      presc_r  <= '0;
      report_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      run_r   <= run_nxt;
      pos_r   <= pos_nxt;
      en_r    <= en_nxt;
      ctrl_r  <= ctrl_nxt;
      dir_r   <= dir_nxt;
      half_r  <= half_nxt;
      presc_r <= presc_nxt;
      if (in_fire) begin
        report_r <= report_nxt;
      end
    end
  end

  // Board id register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      board_r <= 4'd8;
    end else if (cfg_fire) begin
      unique case (cfg_ch.index)
        CFG_BOARD_ADDRESS:     board_r <= cfg_ch.data[3:0];
        CFG_INITIAL_HALF_FULL: board_r <= board_r;
        default:               board_r <= board_r;
      endcase
    end
  end

  // Result valid: set by each input transaction, cleared when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // State registers drive the result; only a config write can change them while it waits.
  assign out_ch.valid          = out_valid_r;
  assign out_ch.motor_enable   = en_r;
  assign out_ch.pulses_running = run_r;
  assign out_ch.direction_ccw  = dir_r;
  assign out_ch.half_full      = half_r;
  assign out_ch.control_level  = ctrl_r;
  assign out_ch.prescale       = presc_r;
  assign out_ch.position       = $signed(pos_r);
  assign out_ch.report_valid   = report_r;

  // Checks on the frame, step and result logic.
  `SCFC_ASSERT_NEXT(a_star_closes_frame, is_byte && is_star, idx_r == '0, "frame index not cleared by end of frame")
  `SCFC_ASSERT_NEXT(a_idle_pulse_holds, is_pulse && !run_r, $stable(pos_r) && !run_r, "pulse moved a stopped motor")
  `SCFC_ASSERT_NEXT(a_pulse_steps, is_pulse && run_r, pos_r != $past(pos_r), "running pulse did not move position")
  `SCFC_ASSERT_NEXT(a_result_loaded, in_fire, out_valid_r, "accepted transaction produced no result")
  `SCFC_ASSERT_SAME(a_index_bounded, 1'b1, idx_r <= IDX_W'(MAX_FRAME), "frame index past limit")

endmodule
